// ===== rtl/core/mux_frame_deframer_top_macros.svh =====
// Assertion macros used by the deframer RTL.
`ifndef MUX_FRAME_DEFRAMER_TOP_MACROS_SVH
`define MUX_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mfd_pkg.sv =====
// Constants and codes of the multiplexing frame deframer.
package mfd_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned UPD_BYTES = 8;

  localparam logic [7:0]  UPD_VERSION   = 8'd2;
  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [16:0] LIMIT_RESET   = 17'd65543;

  localparam int unsigned TDATA_W = 112;
  localparam int unsigned PADDR_W = 3;

  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  localparam logic [7:0] CMD_SYN = 8'd0;
  localparam logic [7:0] CMD_FIN = 8'd1;
  localparam logic [7:0] CMD_PSH = 8'd2;
  localparam logic [7:0] CMD_NOP = 8'd3;
  localparam logic [7:0] CMD_UPD = 8'd4;

  localparam logic [2:0] EV_OPEN   = 3'd0;
  localparam logic [2:0] EV_FINISH = 3'd1;
  localparam logic [2:0] EV_DATA   = 3'd2;
  localparam logic [2:0] EV_UPDATE = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  localparam logic [1:0] ERR_VERSION  = 2'd0;
  localparam logic [1:0] ERR_COMMAND  = 2'd1;
  localparam logic [1:0] ERR_UPDATE   = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

endpackage

// ===== rtl/core/mux_frame_deframer_top.sv =====
// Byte-serial multiplexing frame deframer with APB register port.
// Output: a result is registered and appears on m_axis in the cycle after its byte transaction.
// Throughput: one byte per cycle, set by the single result register that
// parts the input from m_axis; bytes flow whenever m_axis is not stalled.
// Reset: synchronous; parser returns to header byte zero, session open,
// registers to version 1 and limit 65543, no result pending.
module mux_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // stream[31:0], data_byte[39:32], consumed_count[71:40],
  // window_size[103:72], err_code[105:104], zero[111:106]
  output logic [mfd_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast,   // last_of_frame
  output logic [2:0]                    m_axis_tuser,   // event_kind
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

`include "mux_frame_deframer_top_macros.svh"

  logic [7:0]  expected_version;
  logic [16:0] buffer_limit;

  logic        in_payload, in_payload_next;
  logic [15:0] byte_index, byte_index_next;
  logic [7:0]  frame_version, frame_version_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [15:0] frame_length, frame_length_next;
  logic [31:0] frame_stream, frame_stream_next;
  logic [63:0] update_words, update_words_next;
  logic        session_dead, session_dead_next;

  logic        out_valid;
  logic [2:0]  out_kind;
  logic [31:0] out_stream;
  logic [7:0]  out_data;
  logic        out_last;
  logic [31:0] out_consumed;
  logic [31:0] out_window;
  logic [1:0]  out_err;
  logic        out_is_error;

  logic        res_valid;
  logic [2:0]  res_kind;
  logic [31:0] res_stream;
  logic [7:0]  res_data;
  logic        res_last;
  logic [31:0] res_consumed;
  logic [31:0] res_window;
  logic [1:0]  res_err;

  logic        fin_valid;
  logic [2:0]  fin_kind;
  logic [1:0]  fin_err;

  logic        in_accept;
  logic        cfg_write;
  logic [16:0] pos;
  logic        frame_end;

  assign pready        = 1'b1;
  assign cfg_write     = psel && penable && pwrite && pready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= mfd_pkg::VERSION_RESET;
      buffer_limit     <= mfd_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        mfd_pkg::REG_VERSION: expected_version <= pwdata[7:0];
        mfd_pkg::REG_LIMIT:   buffer_limit     <= pwdata[16:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mfd_pkg::REG_VERSION: prdata = {24'd0, expected_version};
      mfd_pkg::REG_LIMIT:   prdata = {15'd0, buffer_limit};
      default:              prdata = 32'd0;
    endcase
  end

  assign pos = in_payload ? (17'(mfd_pkg::HDR_BYTES) + {1'b0, byte_index})
                          : {1'b0, byte_index};
  assign frame_end = (17'({1'b0, byte_index}) + 17'd1) >= {1'b0, frame_length};

  // Decode the end-of-frame event from the held command and length and the expected version.
  always_comb begin
    fin_valid = 1'b0;
    fin_kind  = mfd_pkg::EV_OPEN;
    fin_err   = mfd_pkg::ERR_VERSION;
    case (frame_command)
      mfd_pkg::CMD_SYN: begin
        fin_valid = 1'b1;
        fin_kind  = mfd_pkg::EV_OPEN;
      end
      mfd_pkg::CMD_FIN: begin
        fin_valid = 1'b1;
        fin_kind  = mfd_pkg::EV_FINISH;
      end
      mfd_pkg::CMD_PSH, mfd_pkg::CMD_NOP: fin_valid = 1'b0;
      mfd_pkg::CMD_UPD: begin
        fin_valid = 1'b1;
        if (expected_version != mfd_pkg::UPD_VERSION ||
            frame_length != 16'(mfd_pkg::UPD_BYTES)) begin
          fin_kind = mfd_pkg::EV_ERROR;
          fin_err  = mfd_pkg::ERR_UPDATE;
        end else begin
          fin_kind = mfd_pkg::EV_UPDATE;
        end
      end
      default: begin
        fin_valid = 1'b1;
        fin_kind  = mfd_pkg::EV_ERROR;
        fin_err   = mfd_pkg::ERR_COMMAND;
      end
    endcase
  end

  always_comb begin
    in_payload_next    = in_payload;
    byte_index_next    = byte_index;
    frame_version_next = frame_version;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    frame_stream_next  = frame_stream;
    update_words_next  = update_words;
    session_dead_next  = session_dead;

    res_valid    = 1'b0;
    res_kind     = mfd_pkg::EV_OPEN;
    res_stream   = 32'd0;
    res_data     = 8'd0;
    res_last     = 1'b0;
    res_consumed = 32'd0;
    res_window   = 32'd0;
    res_err      = mfd_pkg::ERR_VERSION;

    if (!session_dead) begin
      if (pos >= buffer_limit) begin
        res_valid         = 1'b1;
        res_kind          = mfd_pkg::EV_ERROR;
        res_err           = mfd_pkg::ERR_OVERFLOW;
        session_dead_next = 1'b1;
      end else if (!in_payload) begin
        case (byte_index[2:0])
          3'd0:    frame_version_next = s_axis_tdata;
          3'd1:    frame_command_next = s_axis_tdata;
          3'd2:    frame_length_next[7:0] = s_axis_tdata;
          3'd3:    frame_length_next[15:8] = s_axis_tdata;
          default: frame_stream_next[8*(byte_index[1:0]) +: 8] = s_axis_tdata;
        endcase
        if (byte_index[2:0] != 3'(mfd_pkg::HDR_BYTES - 1)) begin
          byte_index_next = byte_index + 16'd1;
        end else if (frame_version != expected_version) begin
          res_valid         = 1'b1;
          res_kind          = mfd_pkg::EV_ERROR;
          res_err           = mfd_pkg::ERR_VERSION;
          session_dead_next = 1'b1;
        end else begin
          update_words_next = 64'd0;
          byte_index_next   = 16'd0;
          if (frame_length == 16'd0) begin
            res_valid = fin_valid;
            res_kind  = fin_kind;
            res_err   = fin_err;
            if (fin_kind == mfd_pkg::EV_ERROR) begin
              session_dead_next = 1'b1;
            end else begin
              res_stream   = frame_stream_next;
              res_consumed = update_words_next[31:0];
              res_window   = update_words_next[63:32];
            end
          end else begin
            in_payload_next = 1'b1;
          end
        end
      end else begin
        if (frame_command == mfd_pkg::CMD_UPD &&
            byte_index < 16'(mfd_pkg::UPD_BYTES)) begin
          update_words_next[8*byte_index[2:0] +: 8] = s_axis_tdata;
        end
        if (frame_command == mfd_pkg::CMD_PSH) begin
          res_valid  = 1'b1;
          res_kind   = mfd_pkg::EV_DATA;
          res_stream = frame_stream;
          res_data   = s_axis_tdata;
          res_last   = frame_end;
        end
        if (frame_end) begin
          in_payload_next = 1'b0;
          byte_index_next = 16'd0;
          if (frame_command != mfd_pkg::CMD_PSH) begin
            res_valid = fin_valid;
            res_kind  = fin_kind;
            res_err   = fin_err;
            if (fin_kind == mfd_pkg::EV_ERROR) begin
              session_dead_next = 1'b1;
            end else begin
              res_stream   = frame_stream;
              res_consumed = update_words_next[31:0];
              res_window   = update_words_next[63:32];
            end
          end
        end else begin
          byte_index_next = byte_index + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      byte_index    <= 16'd0;
      frame_version <= 8'd0;
      frame_command <= 8'd0;
      frame_length  <= 16'd0;
      frame_stream  <= 32'd0;
      update_words  <= 64'd0;
      session_dead  <= 1'b0;
    end else if (in_accept) begin
      in_payload    <= in_payload_next;
      byte_index    <= byte_index_next;
      frame_version <= frame_version_next;
      frame_command <= frame_command_next;
      frame_length  <= frame_length_next;
      frame_stream  <= frame_stream_next;
      update_words  <= update_words_next;
      session_dead  <= session_dead_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_kind     <= res_kind;
      out_stream   <= res_stream;
      out_data     <= res_data;
      out_last     <= res_last;
      out_consumed <= res_consumed;
      out_window   <= res_window;
      out_err      <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {6'd0, out_err, out_window, out_consumed, out_data, out_stream};

  assign out_is_error = out_valid && (out_kind == mfd_pkg::EV_ERROR);

  `MFD_ASSERT_NEXT(a_dead_sticks, session_dead, session_dead, "session left dead state")
  `MFD_ASSERT_NOW(a_error_kills, out_is_error, session_dead, "error with session open")
  `MFD_ASSERT_NOW(a_index_in_frame, in_payload, byte_index < frame_length, "index past length")
  `MFD_ASSERT_NOW(a_last_is_data, out_valid && out_last, out_kind == mfd_pkg::EV_DATA, "bad tlast")

endmodule

// ===== verif/tb_mux_frame_deframer_top.sv =====
// Self-checking testbench for the multiplexing frame deframer: byte stream in, events out.
module tb_mux_frame_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] stream;
    logic [7:0]  data;
    logic        last;
    logic [31:0] consumed;
    logic [31:0] window;
    logic [1:0]  code;
  } deframe_evt_t;

  logic                          clk;
  logic                          rst;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [mfd_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                          m_axis_tlast;
  logic [2:0]                    m_axis_tuser;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [mfd_pkg::PADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // deframer model state and register copies
  logic [7:0]   cfg_version  = mfd_pkg::VERSION_RESET;
  logic [16:0]  cfg_limit    = mfd_pkg::LIMIT_RESET;
  logic         p_in_payload = 1'b0;
  logic [15:0]  p_index      = '0;
  logic [7:0]   p_version    = '0;
  logic [7:0]   p_command    = '0;
  logic [15:0]  p_length     = '0;
  logic [31:0]  p_stream     = '0;
  logic [63:0]  p_update     = '0;
  logic         p_dead       = 1'b0;

  deframe_evt_t pending_events[$];
  deframe_evt_t want_evt;

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int          idle_pct       = 0;
  int          stall_pct      = 0;
  int          hold_len       = 0;
  int          hold_serial    = 0;

  mux_frame_deframer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic push_event(input logic [2:0] kind, input logic [31:0] stream,
                            input logic [7:0] data, input logic last,
                            input logic [31:0] consumed, input logic [31:0] window,
                            input logic [1:0] code);
    deframe_evt_t e;
    e.kind     = kind;
    e.stream   = stream;
    e.data     = data;
    e.last     = last;
    e.consumed = consumed;
    e.window   = window;
    e.code     = code;
    pending_events = {pending_events, e};
  endtask

  task automatic raise_error(input logic [1:0] code);
    push_event(mfd_pkg::EV_ERROR, '0, '0, 1'b0, '0, '0, code);
    p_dead = 1'b1;
  endtask

  task automatic close_frame();
    p_in_payload = 1'b0;
    p_index      = '0;
    case (p_command)
      mfd_pkg::CMD_SYN: push_event(mfd_pkg::EV_OPEN, p_stream, '0, 1'b0, '0, '0, '0);
      mfd_pkg::CMD_FIN: push_event(mfd_pkg::EV_FINISH, p_stream, '0, 1'b0, '0, '0, '0);
      mfd_pkg::CMD_PSH, mfd_pkg::CMD_NOP: ;
      mfd_pkg::CMD_UPD: begin
        if (cfg_version != mfd_pkg::UPD_VERSION || p_length != mfd_pkg::UPD_BYTES) begin
          raise_error(mfd_pkg::ERR_UPDATE);
        end else begin
          push_event(mfd_pkg::EV_UPDATE, p_stream, '0, 1'b0, p_update[31:0],
                     p_update[63:32], '0);
        end
      end
      default: raise_error(mfd_pkg::ERR_COMMAND);
    endcase
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int unsigned pos;
    if (p_dead) return;
    pos = p_in_payload ? mfd_pkg::HDR_BYTES + p_index : p_index;
    if (pos + 1 > cfg_limit) begin
      raise_error(mfd_pkg::ERR_OVERFLOW);
      return;
    end
    if (!p_in_payload) begin
      case (p_index)
        0: p_version = b;
        1: p_command = b;
        2: p_length = {8'h00, b};
        3: p_length[15:8] = b;
        4: p_stream = {24'h0, b};
        default: p_stream[8*(p_index-4) +: 8] = b;
      endcase
      if (p_index < mfd_pkg::HDR_BYTES - 1) begin
        p_index++;
        return;
      end
      if (p_version != cfg_version) begin
        raise_error(mfd_pkg::ERR_VERSION);
        return;
      end
      p_update = '0;
      p_index  = '0;
      if (p_length == 0) close_frame();
      else p_in_payload = 1'b1;
      return;
    end
    if (p_command == mfd_pkg::CMD_UPD && p_index < mfd_pkg::UPD_BYTES) begin
      p_update[8*p_index +: 8] = b;
    end
    if (p_index + 1 >= p_length) begin
      if (p_command == mfd_pkg::CMD_PSH) begin
        p_in_payload = 1'b0;
        p_index      = '0;
        push_event(mfd_pkg::EV_DATA, p_stream, b, 1'b1, '0, '0, '0);
      end else begin
        close_frame();
      end
      return;
    end
    p_index++;
    if (p_command == mfd_pkg::CMD_PSH) begin
      push_event(mfd_pkg::EV_DATA, p_stream, b, 1'b0, '0, '0, '0);
    end
  endtask

  // compare every m_axis transaction with the oldest expected event
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with none expected");
      end else begin
        want_evt = pending_events[0];
        pending_events.delete(0);
        check_field("event_kind", m_axis_tuser, want_evt.kind);
        check_field("stream", m_axis_tdata[31:0], want_evt.stream);
        check_field("data_byte", m_axis_tdata[39:32], want_evt.data);
        check_field("last_of_frame", m_axis_tlast, want_evt.last);
        check_field("consumed_count", m_axis_tdata[71:40], want_evt.consumed);
        check_field("window_size", m_axis_tdata[103:72], want_evt.window);
        check_field("err_code", m_axis_tdata[105:104], want_evt.code);
      end
    end
  end

  // receiver: random stalls plus counted hold-off stretches
  initial begin
    int hold_taken;
    int hold_left;
    hold_taken = 0;
    hold_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_serial != hold_taken) begin
        hold_taken = hold_serial;
        hold_left  = hold_len;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= !(stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [7:0] cmd,
                             input logic [15:0] len, input logic [31:0] sid);
    send_byte(ver);
    send_byte(cmd);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < 4; i++) send_byte(sid[8*i +: 8]);
  endtask

  task automatic send_full_frame(input logic [7:0] ver, input logic [7:0] cmd,
                                 input logic [15:0] len, input logic [31:0] sid);
    send_header(ver, cmd, len, sid);
    for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic drain_events();
    stop_sending();
    while (pending_events.size() != 0) @(posedge clk);
    // let a frame without a result finish inside the block
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mfd_pkg::PADDR_W'(int'(reg_sel) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_sel)
      mfd_pkg::REG_VERSION: begin
        cfg_version = value[7:0];
        readback    = {24'h0, value[7:0]};
      end
      mfd_pkg::REG_LIMIT: begin
        cfg_limit = value[16:0];
        readback  = {15'h0, value[16:0]};
      end
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", prdata, readback);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] ver, input logic [16:0] limit);
    logic [31:0] junk;
    drain_events();
    junk = $urandom();
    write_reg(mfd_pkg::REG_VERSION, {junk[31:8], ver});
    write_reg(mfd_pkg::REG_LIMIT, {junk[14:0], limit});
  endtask

  task automatic random_frame();
    logic [7:0]  cmd;
    logic [31:0] sid;
    int unsigned len;
    int unsigned room;
    int unsigned r;
    room = cfg_limit - mfd_pkg::HDR_BYTES;
    r = $urandom_range(9, 0);
    if (r == 0) cmd = mfd_pkg::CMD_SYN;
    else if (r == 1) cmd = mfd_pkg::CMD_FIN;
    else if (r == 7) cmd = mfd_pkg::CMD_NOP;
    else if (r >= 8 && cfg_version == mfd_pkg::UPD_VERSION && room >= mfd_pkg::UPD_BYTES)
      cmd = mfd_pkg::CMD_UPD;
    else cmd = mfd_pkg::CMD_PSH;
    r = $urandom_range(99, 0);
    if (cmd == mfd_pkg::CMD_UPD) len = mfd_pkg::UPD_BYTES;
    else if (r < 70) len = $urandom_range(6, 0);
    else if (r < 95) len = $urandom_range(40, 7);
    else len = $urandom_range(300, 41);
    if (len > room) len = $urandom_range(room, 0);
    r = $urandom_range(9, 0);
    sid = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom());
    send_full_frame(cfg_version, cmd, 16'(len), sid);
  endtask

  task automatic test_basic_commands();
    idle_pct  = 0;
    stall_pct = 0;
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_SYN, 16'd0, 32'h0);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_FIN, 16'd0, 32'hFFFF_FFFF);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'd1, 32'h8000_0001);
    send_byte(8'hFF);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'd0, 32'h0000_0100);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_NOP, 16'd2, 32'h1234_5678);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_SYN, 16'd1, 32'h00FF_00FF);
    send_byte(8'h55);
    send_header(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'd3, 32'hA5A5_5A5A);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  task automatic test_update_frames();
    configure(mfd_pkg::UPD_VERSION, mfd_pkg::LIMIT_RESET);
    send_full_frame(mfd_pkg::UPD_VERSION, mfd_pkg::CMD_UPD, 16'(mfd_pkg::UPD_BYTES),
                    32'($urandom()));
    send_header(mfd_pkg::UPD_VERSION, mfd_pkg::CMD_UPD, 16'(mfd_pkg::UPD_BYTES),
                32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_byte(8'h00);
    for (int i = 0; i < 4; i++) send_byte(8'hFF);
    send_full_frame(mfd_pkg::UPD_VERSION, mfd_pkg::CMD_SYN, 16'd0, 32'($urandom()));
  endtask

  task automatic test_version_extremes();
    configure(8'h00, mfd_pkg::LIMIT_RESET);
    send_full_frame(8'h00, mfd_pkg::CMD_SYN, 16'd0, 32'($urandom()));
    send_full_frame(8'h00, mfd_pkg::CMD_PSH, 16'd2, 32'($urandom()));
    // a limit of one header admits only empty frames
    configure(8'hFF, 17'd8);
    send_full_frame(8'hFF, mfd_pkg::CMD_FIN, 16'd0, 32'($urandom()));
    send_full_frame(8'hFF, mfd_pkg::CMD_NOP, 16'd0, 32'($urandom()));
  endtask

  task automatic test_limit_boundary();
    int unsigned n;
    n = $urandom_range(30, 1);
    configure(mfd_pkg::VERSION_RESET, 17'(mfd_pkg::HDR_BYTES + n));
    send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'(n), 32'($urandom()));
    send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_SYN, 16'(n), 32'($urandom()));
  endtask

  task automatic test_long_frame();
    configure(mfd_pkg::VERSION_RESET, mfd_pkg::LIMIT_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'h0100, 32'($urandom()));
  endtask

  task automatic test_backpressure();
    configure(mfd_pkg::VERSION_RESET, mfd_pkg::LIMIT_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_len = 300;
    hold_serial++;
    send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH, 16'd80, 32'($urandom()));
    // hold input until every event is out
    drain_events();
    send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_SYN, 16'd0, 32'($urandom()));
  endtask

  task automatic test_random_traffic(input logic [7:0] ver, input logic [16:0] limit,
                                     input int idle, input int stall, input int count);
    int unsigned start;
    configure(ver, limit);
    idle_pct  = idle;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent - start < count) random_frame();
  endtask

  // an error kills the session for good, so it comes last
  task automatic test_dead_session();
    logic [1:0]  code;
    logic [7:0]  ver;
    logic [16:0] lim;
    int unsigned len;
    code = 2'($urandom_range(3, 0));
    case (code)
      mfd_pkg::ERR_VERSION: begin
        ver = 8'($urandom_range(255, 0));
        configure(ver, mfd_pkg::LIMIT_RESET);
        send_full_frame(8'(ver + 1), 8'($urandom_range(3, 0)), 16'($urandom_range(4, 0)),
                        32'($urandom()));
      end
      mfd_pkg::ERR_COMMAND: begin
        configure(mfd_pkg::VERSION_RESET, mfd_pkg::LIMIT_RESET);
        send_full_frame(mfd_pkg::VERSION_RESET, 8'($urandom_range(255, 5)),
                        16'($urandom_range(5, 0)), 32'($urandom()));
      end
      mfd_pkg::ERR_UPDATE: begin
        if ($urandom_range(1, 0) == 1) begin
          configure(mfd_pkg::UPD_VERSION, mfd_pkg::LIMIT_RESET);
          len = $urandom_range(19, 0);
          if (len >= mfd_pkg::UPD_BYTES) len++;
          send_full_frame(mfd_pkg::UPD_VERSION, mfd_pkg::CMD_UPD, 16'(len),
                          32'($urandom()));
        end else begin
          ver = 8'($urandom_range(255, 0));
          if (ver == mfd_pkg::UPD_VERSION) ver = mfd_pkg::VERSION_RESET;
          configure(ver, mfd_pkg::LIMIT_RESET);
          send_full_frame(ver, mfd_pkg::CMD_UPD, 16'(mfd_pkg::UPD_BYTES), 32'($urandom()));
        end
      end
      mfd_pkg::ERR_OVERFLOW: begin
        lim = 17'(mfd_pkg::HDR_BYTES + $urandom_range(20, 0));
        configure(mfd_pkg::VERSION_RESET, lim);
        send_full_frame(mfd_pkg::VERSION_RESET, mfd_pkg::CMD_PSH,
                        16'(lim - mfd_pkg::HDR_BYTES + 1 + $urandom_range(5, 0)),
                        32'($urandom()));
      end
    endcase
    idle_pct  = 35;
    stall_pct = 35;
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(255, 0)));
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_update_frames();
    test_version_extremes();
    test_limit_boundary();
    test_long_frame();
    test_backpressure();
    test_random_traffic(mfd_pkg::UPD_VERSION, mfd_pkg::LIMIT_RESET, 0, 0, 200);
    test_random_traffic(8'($urandom_range(255, 0)), 17'($urandom_range(128, 16)),
                        59, 0, 200);
    test_random_traffic(mfd_pkg::UPD_VERSION, 17'd24, 0, 59, 200);
    test_random_traffic(8'($urandom_range(255, 0)), mfd_pkg::LIMIT_RESET, 35, 35, 200);
    test_dead_session();

    drain_events();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== mux_frame_deframer_top.f =====
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mux_frame_deframer_top.sv
verif/tb_mux_frame_deframer_top.sv
